// File: design/timestamped_pid_controller_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped PID controller core
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_PID_CONTROLLER_CORE_ASSERT_SVH
`define TIMESTAMPED_PID_CONTROLLER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TPID_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define TPID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tpid_pkg.sv
// ----------------------------------------------------------------------------
// tpid_pkg
// Types, widths and constants of the timestamped PID controller core.
// ----------------------------------------------------------------------------
package tpid_pkg;

    localparam int DATA_W    = 16;             // Q8.8 samples, gains, limits
    localparam int TS_W      = 32;             // timestamp field width
    localparam int S_DATA_W  = DATA_W + TS_W;  // input tdata width
    localparam int CFG_IDX_W = 3;
    localparam int ERR_W     = DATA_W + 1;     // error and measurement difference
    localparam int MC_W      = 56;             // multiplicand magnitude
    localparam int MP_W      = 16;             // multiplier magnitude, one bit a cycle
    localparam int PROD_W    = MC_W + MP_W;
    localparam int SAT_W     = PROD_W + 1;     // signed product
    localparam int INT_W     = 56;             // integral accumulator
    localparam int ACC_W     = INT_W + 2;      // integral update headroom
    localparam int NUM_W     = 31;             // derivative numerator magnitude
    localparam int SUM_W     = 64;             // Q48.16 term sum
    localparam int CNT_W     = 5;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MP_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    // integral product saturation and accumulator limits
    localparam logic signed [SAT_W-1:0] INT_SAT_P = SAT_W'(1) << (INT_W - 1);
    localparam logic signed [SAT_W-1:0] INT_SAT_N = -INT_SAT_P;
    localparam logic signed [ACC_W-1:0] INT_STEP_P = ACC_W'(1) << (INT_W - 1);
    localparam logic signed [ACC_W-1:0] INT_STEP_N = -INT_STEP_P;
    localparam logic signed [ACC_W-1:0] INT_MAX_A = INT_STEP_P - ACC_W'(1);

    // integral term saturation, +-2^60
    localparam logic signed [SAT_W-1:0] ITERM_SAT_P = SAT_W'(1) << 60;
    localparam logic signed [SAT_W-1:0] ITERM_SAT_N = -ITERM_SAT_P;
    localparam logic signed [SUM_W-1:0] ITERM_P = SUM_W'(1) << 60;
    localparam logic signed [SUM_W-1:0] ITERM_N = -ITERM_P;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(128);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd5;

    localparam logic signed [DATA_W-1:0] GAIN_P_RST  = 16'sd256;
    localparam logic signed [DATA_W-1:0] FLOOR_RST   = -16'sd256;
    localparam logic signed [DATA_W-1:0] CEILING_RST = 16'sd256;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_SIGN   = 7'b0000100,
        ST_POST   = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_DSIGN  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        OP_INT = 2'd0,   // elapsed ticks times error
        OP_P   = 2'd1,   // proportional
        OP_D   = 2'd2,   // derivative numerator
        OP_I   = 2'd3    // integral term
    } op_t;

    function automatic logic [MP_W-1:0] mag_err(input logic signed [ERR_W-1:0] x);
        logic signed [ERR_W-1:0] n;
        n = -x;
        return x[ERR_W-1] ? n[MP_W-1:0] : x[MP_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag_gain(input logic signed [DATA_W-1:0] x);
        logic [DATA_W-1:0] n;
        n = -x;
        return x[DATA_W-1] ? n : x;
    endfunction

    function automatic logic [INT_W-1:0] mag_int(input logic signed [INT_W-1:0] x);
        logic [INT_W-1:0] n;
        n = -x;
        return x[INT_W-1] ? n : x;
    endfunction

endpackage

// File: design/timestamped_pid_controller_core.sv
// ----------------------------------------------------------------------------
// timestamped_pid_controller_core
// PID controller on timestamped Q8.8 samples with a clamped Q8.8 drive output.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one transfer per sample, tdata = {sample_time, measured_value}.
//   m_ channel: one transfer per sample, tdata = drive_value, tuser = was_clamped.
//   cfg_ port: one register write per cycle with cfg_wr_en high, indexes 0..5
//   (gains P/I/D, setpoint, floor, ceiling); other indexes are ignored. A
//   setpoint write clears the integral. Write only while the core is idle.
// Timing
//   Products come from one shared shift-add multiplier that retires one
//   multiplier bit per cycle, then a sign step and an update step; the
//   derivative quotient comes from a restoring divider, one quotient bit
//   per cycle, then a sign step. A sample occupies the core through the
//   integral update (if history), P, D with divide (if applied) and I (if used).
//   s_tready is high only while the sequencer is idle.
// Stall
//   The result sits in an output register until taken; the next sample is
//   accepted meanwhile and its result waits in the final step until free.
// Reset
//   Synchronous, active low: registers back to defaults, integral and sample
//   history cleared, both channels empty.
// ----------------------------------------------------------------------------
`include "timestamped_pid_controller_core_assert.svh"

module timestamped_pid_controller_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [tpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpid_pkg::DATA_W-1:0]         cfg_wdata,
    // sample input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tpid_pkg::S_DATA_W-1:0]       s_tdata,   // [15:0] measured_value,
                                                           // [47:16] sample_time
    // drive output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tpid_pkg::DATA_W-1:0]         m_tdata,   // [15:0] drive_value
    output logic [0:0]                          m_tuser    // [0] was_clamped
);

    // timestamps beyond the 32-bit field carry no information
    localparam int TW = (TIME_BITS < tpid_pkg::TS_W) ? TIME_BITS : tpid_pkg::TS_W;
    localparam int DW = tpid_pkg::DATA_W;
    localparam int EW = tpid_pkg::ERR_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tpid_pkg::state_t state_reg, state_next;
    tpid_pkg::op_t    op_reg, op_next;
    logic [tpid_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [DW-1:0] gain_p_reg, gain_p_next;
    logic signed [DW-1:0] gain_i_reg, gain_i_next;
    logic signed [DW-1:0] gain_d_reg, gain_d_next;
    logic signed [DW-1:0] target_reg, target_next;
    logic signed [DW-1:0] floor_reg, floor_next;
    logic signed [DW-1:0] ceiling_reg, ceiling_next;

    logic signed [tpid_pkg::INT_W-1:0] integ_reg, integ_next;
    logic signed [DW-1:0]              last_meas_reg, last_meas_next;
    logic [TW-1:0]                     last_time_reg, last_time_next;
    logic                              have_last_reg, have_last_next;

    // per-sample working set
    logic                 prev_reg, prev_next;     // a previous sample existed
    logic signed [EW-1:0] err_reg, err_next;
    logic signed [EW-1:0] diff_reg, diff_next;
    logic signed [TW:0]   dt_reg, dt_next;

    // shift-add multiplier
    logic [tpid_pkg::MC_W-1:0]  mcand_reg, mcand_next;
    logic [tpid_pkg::MC_W-1:0]  acc_reg, acc_next;
    logic [tpid_pkg::MP_W-1:0]  mplier_reg, mplier_next;
    logic                       neg_reg, neg_next;
    logic signed [tpid_pkg::SAT_W-1:0] prod_s_reg, prod_s_next;

    // restoring divider
    logic [TW-1:0]              rem_reg, rem_next;
    logic [tpid_pkg::NUM_W-1:0] quo_reg, quo_next;

    logic signed [tpid_pkg::SUM_W-1:0] sum_reg, sum_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [DW-1:0] m_data_reg, m_data_next;
    logic          m_clamp_reg, m_clamp_next;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic                 s_accept;
    logic signed [DW-1:0] in_meas;
    logic [TW-1:0]        in_time;
    logic signed [EW-1:0] in_err;
    logic signed [EW-1:0] in_diff;
    logic signed [TW:0]   in_dt;
    logic signed [TW:0]   in_dt_neg;
    logic [TW-1:0]        in_dt_mag;

    logic [tpid_pkg::MC_W:0]    mul_sum;
    logic [tpid_pkg::PROD_W-1:0] prod_mag;

    logic [TW:0] div_shift;
    logic [TW:0] div_sub;
    logic        div_ge;

    logic        use_d;
    logic        use_i;

    logic signed [tpid_pkg::ACC_W-1:0] int_step;
    logic signed [tpid_pkg::ACC_W-1:0] int_sum;
    logic signed [tpid_pkg::SUM_W-1:0] iterm;
    logic signed [tpid_pkg::SUM_W-1:0] quo_ext;

    logic signed [tpid_pkg::SUM_W-1:0] ceil_s;
    logic signed [tpid_pkg::SUM_W-1:0] floor_s;
    logic signed [tpid_pkg::SUM_W-1:0] rounded;
    logic                              out_free;

    assign s_accept  = s_tvalid && s_tready;
    assign in_meas   = $signed(s_tdata[DW-1:0]);
    assign in_time   = s_tdata[DW +: TW];
    assign in_err    = $signed({target_reg[DW-1], target_reg}) -
                       $signed({in_meas[DW-1], in_meas});
    assign in_diff   = $signed({last_meas_reg[DW-1], last_meas_reg}) -
                       $signed({in_meas[DW-1], in_meas});
    assign in_dt     = $signed({1'b0, in_time}) - $signed({1'b0, last_time_reg});
    assign in_dt_neg = -in_dt;
    assign in_dt_mag = in_dt[TW] ? in_dt_neg[TW-1:0] : in_dt[TW-1:0];

    // one multiplier bit per cycle, product shifts down into mplier_reg
    assign mul_sum  = {1'b0, acc_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);
    assign prod_mag = {acc_reg, mplier_reg};

    // one quotient bit per cycle; rem_reg stays below the positive dt
    assign div_shift = {rem_reg, quo_reg[tpid_pkg::NUM_W-1]};
    assign div_sub   = div_shift - {1'b0, dt_reg[TW-1:0]};
    assign div_ge    = (div_shift >= {1'b0, dt_reg[TW-1:0]});

    assign use_d = (gain_d_reg != '0) && prev_reg && !dt_reg[TW] && (dt_reg != '0);
    assign use_i = (gain_i_reg != '0);

    // elapsed * error, saturated, then accumulated with saturation
    always_comb begin
        if (prod_s_reg > tpid_pkg::INT_SAT_P) begin
            int_step = tpid_pkg::INT_STEP_P;
        end else if (prod_s_reg < tpid_pkg::INT_SAT_N) begin
            int_step = tpid_pkg::INT_STEP_N;
        end else begin
            int_step = prod_s_reg[tpid_pkg::ACC_W-1:0];
        end
        int_sum = int_step + $signed({{2{integ_reg[tpid_pkg::INT_W-1]}}, integ_reg});
    end

    always_comb begin
        if (prod_s_reg > tpid_pkg::ITERM_SAT_P) begin
            iterm = tpid_pkg::ITERM_P;
        end else if (prod_s_reg < tpid_pkg::ITERM_SAT_N) begin
            iterm = tpid_pkg::ITERM_N;
        end else begin
            iterm = prod_s_reg[tpid_pkg::SUM_W-1:0];
        end
    end

    assign quo_ext = $signed({{(tpid_pkg::SUM_W - tpid_pkg::NUM_W){1'b0}}, quo_reg});

    // limits in Q48.16; rounding is add half then floor
    assign ceil_s   = $signed({{(tpid_pkg::SUM_W - DW - 8){ceiling_reg[DW-1]}},
                               ceiling_reg, 8'd0});
    assign floor_s  = $signed({{(tpid_pkg::SUM_W - DW - 8){floor_reg[DW-1]}},
                               floor_reg, 8'd0});
    assign rounded  = sum_reg + tpid_pkg::ROUND_HALF;
    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        target_next    = target_reg;
        floor_next     = floor_reg;
        ceiling_next   = ceiling_reg;
        integ_next     = integ_reg;
        last_meas_next = last_meas_reg;
        last_time_next = last_time_reg;
        have_last_next = have_last_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        dt_next        = dt_reg;
        mcand_next     = mcand_reg;
        acc_next       = acc_reg;
        mplier_next    = mplier_reg;
        neg_next       = neg_reg;
        prod_s_next    = prod_s_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        sum_next       = sum_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_clamp_next   = m_clamp_reg;

        case (state_reg)
            tpid_pkg::ST_IDLE: begin
                if (s_accept) begin
                    err_next       = in_err;
                    diff_next      = in_diff;
                    dt_next        = in_dt;
                    prev_next      = have_last_reg;
                    last_meas_next = in_meas;
                    last_time_next = in_time;
                    have_last_next = 1'b1;
                    acc_next       = '0;
                    cnt_next       = '0;
                    state_next     = tpid_pkg::ST_MUL;
                    if (have_last_reg) begin
                        op_next     = tpid_pkg::OP_INT;
                        mcand_next  = {{(tpid_pkg::MC_W - TW){1'b0}}, in_dt_mag};
                        mplier_next = tpid_pkg::mag_err(in_err);
                        neg_next    = in_dt[TW] ^ in_err[EW-1];
                    end else begin
                        op_next     = tpid_pkg::OP_P;
                        mcand_next  = {{(tpid_pkg::MC_W - DW){1'b0}},
                                       tpid_pkg::mag_gain(gain_p_reg)};
                        mplier_next = tpid_pkg::mag_err(in_err);
                        neg_next    = gain_p_reg[DW-1] ^ in_err[EW-1];
                    end
                end
            end

            tpid_pkg::ST_MUL: begin
                acc_next    = mul_sum[tpid_pkg::MC_W:1];
                mplier_next = {mul_sum[0], mplier_reg[tpid_pkg::MP_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == tpid_pkg::MUL_LAST) begin
                    state_next = tpid_pkg::ST_SIGN;
                end
            end

            tpid_pkg::ST_SIGN: begin
                prod_s_next = neg_reg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
                state_next  = tpid_pkg::ST_POST;
            end

            tpid_pkg::ST_POST: begin
                acc_next = '0;
                cnt_next = '0;
                case (op_reg)
                    tpid_pkg::OP_INT: begin
                        if (int_sum > tpid_pkg::INT_MAX_A) begin
                            integ_next = tpid_pkg::INT_MAX_A[tpid_pkg::INT_W-1:0];
                        end else if (int_sum < tpid_pkg::INT_STEP_N) begin
                            integ_next = tpid_pkg::INT_STEP_N[tpid_pkg::INT_W-1:0];
                        end else begin
                            integ_next = int_sum[tpid_pkg::INT_W-1:0];
                        end
                        op_next     = tpid_pkg::OP_P;
                        mcand_next  = {{(tpid_pkg::MC_W - DW){1'b0}},
                                       tpid_pkg::mag_gain(gain_p_reg)};
                        mplier_next = tpid_pkg::mag_err(err_reg);
                        neg_next    = gain_p_reg[DW-1] ^ err_reg[EW-1];
                        state_next  = tpid_pkg::ST_MUL;
                    end
                    tpid_pkg::OP_P: begin
                        sum_next = prod_s_reg[tpid_pkg::SUM_W-1:0];
                        if (use_d) begin
                            op_next     = tpid_pkg::OP_D;
                            mcand_next  = {{(tpid_pkg::MC_W - DW){1'b0}},
                                           tpid_pkg::mag_gain(gain_d_reg)};
                            mplier_next = tpid_pkg::mag_err(diff_reg);
                            neg_next    = gain_d_reg[DW-1] ^ diff_reg[EW-1];
                            state_next  = tpid_pkg::ST_MUL;
                        end else if (use_i) begin
                            op_next     = tpid_pkg::OP_I;
                            mcand_next  = tpid_pkg::mag_int(integ_reg);
                            mplier_next = tpid_pkg::mag_gain(gain_i_reg);
                            neg_next    = gain_i_reg[DW-1] ^ integ_reg[tpid_pkg::INT_W-1];
                            state_next  = tpid_pkg::ST_MUL;
                        end else begin
                            state_next = tpid_pkg::ST_FINISH;
                        end
                    end
                    tpid_pkg::OP_D: begin
                        // divide the magnitude, sign restored afterwards
                        quo_next   = prod_mag[tpid_pkg::NUM_W-1:0];
                        rem_next   = '0;
                        state_next = tpid_pkg::ST_DIV;
                    end
                    tpid_pkg::OP_I: begin
                        sum_next   = sum_reg + iterm;
                        state_next = tpid_pkg::ST_FINISH;
                    end
                    default: begin
                        state_next = tpid_pkg::ST_FINISH;
                    end
                endcase
            end

            tpid_pkg::ST_DIV: begin
                rem_next = div_ge ? div_sub[TW-1:0] : div_shift[TW-1:0];
                quo_next = {quo_reg[tpid_pkg::NUM_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tpid_pkg::DIV_LAST) begin
                    state_next = tpid_pkg::ST_DSIGN;
                end
            end

            tpid_pkg::ST_DSIGN: begin
                sum_next = neg_reg ? sum_reg - quo_ext : sum_reg + quo_ext;
                acc_next = '0;
                cnt_next = '0;
                if (use_i) begin
                    op_next     = tpid_pkg::OP_I;
                    mcand_next  = tpid_pkg::mag_int(integ_reg);
                    mplier_next = tpid_pkg::mag_gain(gain_i_reg);
                    neg_next    = gain_i_reg[DW-1] ^ integ_reg[tpid_pkg::INT_W-1];
                    state_next  = tpid_pkg::ST_MUL;
                end else begin
                    state_next = tpid_pkg::ST_FINISH;
                end
            end

            tpid_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = tpid_pkg::ST_IDLE;
                    if (sum_reg > ceil_s) begin
                        // floor wins when the limits cross
                        m_data_next  = (ceiling_reg < floor_reg) ? floor_reg : ceiling_reg;
                        m_clamp_next = 1'b1;
                    end else if (sum_reg < floor_s) begin
                        m_data_next  = floor_reg;
                        m_clamp_next = 1'b1;
                    end else begin
                        m_data_next  = rounded[DW+7:8];
                        m_clamp_next = 1'b0;
                    end
                end
            end

            default: begin
                state_next = tpid_pkg::ST_IDLE;
            end
        endcase

        // register writes: the user writes only while idle, the core does not enforce it
        if (cfg_wr_en) begin
            case (cfg_index)
                tpid_pkg::REG_GAIN_P:  gain_p_next  = cfg_wdata;
                tpid_pkg::REG_GAIN_I:  gain_i_next  = cfg_wdata;
                tpid_pkg::REG_GAIN_D:  gain_d_next  = cfg_wdata;
                tpid_pkg::REG_TARGET: begin
                    target_next = cfg_wdata;
                    integ_next  = '0;
                end
                tpid_pkg::REG_FLOOR:   floor_next   = cfg_wdata;
                tpid_pkg::REG_CEILING: ceiling_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tpid_pkg::ST_IDLE;
            op_reg        <= tpid_pkg::OP_INT;
            cnt_reg       <= '0;
            gain_p_reg    <= tpid_pkg::GAIN_P_RST;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            target_reg    <= '0;
            floor_reg     <= tpid_pkg::FLOOR_RST;
            ceiling_reg   <= tpid_pkg::CEILING_RST;
            integ_reg     <= '0;
            last_meas_reg <= '0;
            last_time_reg <= '0;
            have_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            target_reg    <= target_next;
            floor_reg     <= floor_next;
            ceiling_reg   <= ceiling_next;
            integ_reg     <= integ_next;
            last_meas_reg <= last_meas_next;
            last_time_reg <= last_time_next;
            have_last_reg <= have_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        prev_reg    <= prev_next;
        err_reg     <= err_next;
        diff_reg    <= diff_next;
        dt_reg      <= dt_next;
        mcand_reg   <= mcand_next;
        acc_reg     <= acc_next;
        mplier_reg  <= mplier_next;
        neg_reg     <= neg_next;
        prod_s_reg  <= prod_s_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        sum_reg     <= sum_next;
        m_data_reg  <= m_data_next;
        m_clamp_reg <= m_clamp_next;
    end

    assign s_tready = (state_reg == tpid_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_clamp_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TPID_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "core ready right after a transfer")
    `TPID_ASSERT_SAME(a_div_rem_bound, state_reg == tpid_pkg::ST_DIV, rem_reg < dt_reg[TW-1:0], "divider remainder not below divisor")
    `TPID_ASSERT_SAME(a_div_only_forward, state_reg == tpid_pkg::ST_DIV, prev_reg && !dt_reg[TW] && dt_reg != '0, "derivative divide without a forward time step")
    `TPID_ASSERT_NEXT(a_finish_holds, state_reg == tpid_pkg::ST_FINISH && m_tvalid && !m_tready, state_reg == tpid_pkg::ST_FINISH, "result overwrote a stalled output")

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamped PID controller core. Samples are
// queued per register setting and fed through the s_ stream. Each accepted
// sample runs through a bit-true controller model in the bench. The drive
// values taken from the m_ stream are checked in order against that model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int HOLD_CYCLES  = 500;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 150;    // well beyond the worst case for one sample

    // indexes the core does not decode; writes there must change nothing
    localparam logic [tpid_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [tpid_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint INTEG_MAX = (longint'(1) <<< 55) - 1;
    localparam longint INTEG_MIN = -(longint'(1) <<< 55);
    localparam longint STEP_LIM  = longint'(1) <<< 55;
    localparam longint ITERM_LIM = longint'(1) <<< 60;

    // same layout as s_tdata: measurement low, timestamp high
    typedef struct packed {
        logic [tpid_pkg::TS_W-1:0]   stamp;
        logic [tpid_pkg::DATA_W-1:0] level;
    } sample_t;

    typedef struct packed {
        logic [tpid_pkg::DATA_W-1:0] drive;
        logic                        clamped;
    } drive_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [tpid_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tpid_pkg::DATA_W-1:0]    cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tpid_pkg::S_DATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tpid_pkg::DATA_W-1:0]    m_tdata;
    logic [0:0]                     m_tuser;

    timestamped_pid_controller_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Controller model: registers and sample history
    // ------------------------------------------------------------------------
    logic signed [tpid_pkg::DATA_W-1:0] kp, ki, kd, setpoint, floor_lvl, ceil_lvl;
    longint                             integ;
    logic signed [tpid_pkg::DATA_W-1:0] prev_level;
    logic [tpid_pkg::TS_W-1:0]          prev_stamp;
    bit                                 have_prev;

    sample_t samples_to_send[$];   // filled by the sequence, drained by the driver
    drive_t  drive_expected[$];    // model output per accepted sample

    int unsigned tx_idle_pct = 29;
    int unsigned rx_idle_pct = 81;
    bit          stall_armed = 1'b0;

    int n_issued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_clamped  = 0;
    int n_settings = 0;
    int errors     = 0;
    int cycle_count = 0;

    function automatic void reset_model();
        kp         = tpid_pkg::GAIN_P_RST;
        ki         = '0;
        kd         = '0;
        setpoint   = '0;
        floor_lvl  = tpid_pkg::FLOOR_RST;
        ceil_lvl   = tpid_pkg::CEILING_RST;
        integ      = 0;
        prev_level = '0;
        prev_stamp = '0;
        have_prev  = 1'b0;
    endfunction

    function automatic void apply_reg(logic [tpid_pkg::CFG_IDX_W-1:0] idx,
                                      logic [tpid_pkg::DATA_W-1:0] val);
        case (idx)
            tpid_pkg::REG_GAIN_P:  kp = val;
            tpid_pkg::REG_GAIN_I:  ki = val;
            tpid_pkg::REG_GAIN_D:  kd = val;
            tpid_pkg::REG_TARGET: begin
                setpoint = val;
                integ    = 0;          // setpoint change restarts the integral
            end
            tpid_pkg::REG_FLOOR:   floor_lvl = val;
            tpid_pkg::REG_CEILING: ceil_lvl  = val;
            default: ;
        endcase
    endfunction

    // exact product, saturated to +-lim
    function automatic longint sat_product(longint a, longint b, longint lim);
        logic signed [127:0] wa, wb, wide;
        wa   = 128'(a);
        wb   = 128'(b);
        wide = wa * wb;
        if (wide > lim)
            return lim;
        if (wide < -lim)
            return -lim;
        return longint'(wide);
    endfunction

    function automatic drive_t pid_step(sample_t s);
        longint err, dt, acc, total, hi, lo;
        drive_t r;
        err = longint'(setpoint) - longint'($signed(s.level));
        dt  = longint'(s.stamp) - longint'(prev_stamp);
        if (have_prev) begin
            acc = integ + sat_product(dt, err, STEP_LIM);
            if (acc > INTEG_MAX)
                acc = INTEG_MAX;
            else if (acc < INTEG_MIN)
                acc = INTEG_MIN;
            integ = acc;
        end
        total = longint'(kp) * err;
        // derivative on measurement, only once time has moved forward
        if (kd != 0 && have_prev && dt > 0)
            total += (longint'(kd) * (longint'(prev_level) - longint'($signed(s.level)))) / dt;
        if (ki != 0)
            total += sat_product(longint'(ki), integ, ITERM_LIM);
        prev_level = s.level;
        prev_stamp = s.stamp;
        have_prev  = 1'b1;
        hi = longint'(ceil_lvl) * 256;
        lo = longint'(floor_lvl) * 256;
        if (total > hi) begin
            // floor takes precedence when the limits are crossed
            r.drive   = (ceil_lvl < floor_lvl) ? floor_lvl : ceil_lvl;
            r.clamped = 1'b1;
        end else if (total < lo) begin
            r.drive   = floor_lvl;
            r.clamped = 1'b1;
        end else begin
            r.drive   = tpid_pkg::DATA_W'((total + 128) >>> 8);   // nearest, ties upwards
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers queued samples, predicts on each input transfer
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                drive_expected.push_back(pid_step(s_tdata));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= samples_to_send.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each output transfer, drives back-pressure
    // ------------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        drive_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (drive_expected.size() == 0) begin
                    $display("%0t: unexpected output transfer, got drive %0d clamped %0b",
                             $time, $signed(m_tdata), m_tuser[0]);
                    errors++;
                end else begin
                    want = drive_expected.pop_front();
                    if (m_tdata !== want.drive) begin
                        $display("%0t: drive_value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.drive), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser[0] !== want.clamped) begin
                        $display("%0t: was_clamped mismatch, expected %0b, got %0b",
                                 $time, want.clamped, m_tuser[0]);
                        errors++;
                    end
                    if (want.clamped)
                        n_clamped++;
                    n_checked++;
                end
            end
            // one long hold-off so the core fills up and drops s_tready
            if (hold_left != 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (stall_armed && !hold_done) begin
                m_tready  <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timestamped_pid_controller_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [tpid_pkg::CFG_IDX_W-1:0] idx,
                             logic [tpid_pkg::DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // call only away from the rising edge
    function automatic void add_sample(logic [tpid_pkg::DATA_W-1:0] level,
                                       logic [tpid_pkg::TS_W-1:0] stamp);
        sample_t s;
        s.level = level;
        s.stamp = stamp;
        samples_to_send.push_back(s);
        n_issued++;
    endfunction

    // every sample gives exactly one result, so all results in means idle
    task automatic drain();
        while (n_checked != n_issued)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [tpid_pkg::DATA_W-1:0] rand_gain(int max_shift);
        int k;
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 16'h7FFF : 16'h8000;
        k = $urandom_range(max_shift, 0);
        return tpid_pkg::DATA_W'($urandom_range((2 << k) - 1, 0) - (1 << k));
    endfunction

    // one register setting followed by a run of samples; style 1 and 2 pin
    // the gains and setpoint to opposite extremes, style 0 draws them at random
    task automatic run_phase(int style, int count);
        logic [tpid_pkg::DATA_W-1:0] tgt, fa, fb;
        logic [tpid_pkg::TS_W-1:0]   stamp;
        int                          pick, k;
        case (style)
            1: begin
                write_reg(tpid_pkg::REG_GAIN_P, 16'h7FFF);
                write_reg(tpid_pkg::REG_GAIN_I, 16'h8000);
                write_reg(tpid_pkg::REG_GAIN_D, 16'h8000);
                write_reg(tpid_pkg::REG_FLOOR, 16'h8000);
                write_reg(tpid_pkg::REG_CEILING, 16'h7FFF);
                tgt = 16'h7FFF;
            end
            2: begin
                write_reg(tpid_pkg::REG_GAIN_P, 16'h8000);
                write_reg(tpid_pkg::REG_GAIN_I, 16'h7FFF);
                write_reg(tpid_pkg::REG_GAIN_D, 16'h7FFF);
                write_reg(tpid_pkg::REG_FLOOR, 16'h8000);
                write_reg(tpid_pkg::REG_CEILING, 16'h7FFF);
                tgt = 16'h8000;
            end
            default: begin
                write_reg(tpid_pkg::REG_GAIN_P, rand_gain(10));
                write_reg(tpid_pkg::REG_GAIN_I,
                          ($urandom_range(2) == 0) ? 16'h0000 : rand_gain(6));
                write_reg(tpid_pkg::REG_GAIN_D,
                          ($urandom_range(4) == 0) ? 16'h0000 : rand_gain(12));
                pick = $urandom_range(99);
                fa = tpid_pkg::DATA_W'($urandom);
                fb = tpid_pkg::DATA_W'($urandom);
                if (pick < 60) begin
                    write_reg(tpid_pkg::REG_FLOOR, 16'h8000);
                    write_reg(tpid_pkg::REG_CEILING, 16'h7FFF);
                end else if (pick < 85) begin
                    write_reg(tpid_pkg::REG_FLOOR, ($signed(fa) < $signed(fb)) ? fa : fb);
                    write_reg(tpid_pkg::REG_CEILING, ($signed(fa) < $signed(fb)) ? fb : fa);
                end else begin
                    write_reg(tpid_pkg::REG_FLOOR, fa);   // may end up above the ceiling
                    write_reg(tpid_pkg::REG_CEILING, fb);
                end
                tgt = $urandom_range(1) ? tpid_pkg::DATA_W'($urandom)
                                        : tpid_pkg::DATA_W'($urandom_range(511));
            end
        endcase
        write_reg(tpid_pkg::REG_TARGET, tgt);
        n_settings++;
        @(negedge aclk);
        stamp = $urandom;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                stamp = stamp + $urandom_range(1 << $urandom_range(12), 1);
            else if (pick < 78)
                stamp = stamp;                         // time stands still
            else if (pick < 88)
                stamp = stamp - $urandom_range(500, 1); // time steps back
            else
                stamp = $urandom;
            k = $urandom_range(10);
            if ($urandom_range(99) < 85)
                add_sample(tgt + tpid_pkg::DATA_W'($urandom_range((2 << k) - 1, 0) - (1 << k)),
                           stamp);
            else
                add_sample(tpid_pkg::DATA_W'($urandom), stamp);
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: unit P gain, limits at +-1.0
        @(negedge aclk);
        add_sample(16'h0000, 32'd0);          // first sample, no history yet
        add_sample(16'h0080, 32'd10);
        add_sample(16'h7FFF, 32'd10);         // no time step, hits the floor
        add_sample(16'h8000, 32'd5);          // time backwards, hits the ceiling
        add_sample(16'h0001, 32'hFFFF_FFFF);
        add_sample(16'hFFFF, 32'd0);          // largest negative step
        drain();

        // half P gain gives exact ties; derivative switched on
        write_reg(tpid_pkg::REG_GAIN_P, 16'h0080);
        write_reg(tpid_pkg::REG_GAIN_D, 16'h0100);
        write_reg(tpid_pkg::REG_FLOOR, 16'h8000);
        write_reg(tpid_pkg::REG_CEILING, 16'h7FFF);
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hFFFF);
        n_settings++;
        @(negedge aclk);
        add_sample(16'h0001, 32'd100);
        add_sample(16'hFFFF, 32'd101);
        add_sample(16'hFFFF, 32'd101);        // derivative skipped, tie rounds up
        add_sample(16'h0000, 32'd99);
        add_sample(16'h0001, 32'd99);         // tie below zero
        drain();

        // integral path at its limits
        write_reg(tpid_pkg::REG_GAIN_I, 16'h7FFF);
        write_reg(tpid_pkg::REG_GAIN_D, 16'h0000);
        write_reg(tpid_pkg::REG_TARGET, 16'h1000);
        n_settings++;
        @(negedge aclk);
        add_sample(16'h0000, 32'd200);
        add_sample(16'h0000, 32'h0100_0000);
        add_sample(16'h8000, 32'hFFFF_FFFF);
        add_sample(16'h7FFF, 32'd0);
        drain();
        write_reg(tpid_pkg::REG_TARGET, 16'hF000);      // clears the integral
        @(negedge aclk);
        add_sample(16'h1000, 32'd50);
        add_sample(16'hF000, 32'd60);
        drain();

        // floor above ceiling
        write_reg(tpid_pkg::REG_GAIN_I, 16'h0000);
        write_reg(tpid_pkg::REG_FLOOR, 16'h0100);
        write_reg(tpid_pkg::REG_CEILING, 16'hFF00);
        n_settings++;
        @(negedge aclk);
        add_sample(16'h0000, 32'd70);
        add_sample(16'h7FFF, 32'd71);
        add_sample(16'h8000, 32'd72);
        drain();

        // random part: sender 29 % idle, receiver 81 %
        run_phase(1, 100);
        run_phase(0, 100);
        @(negedge aclk);
        tx_idle_pct = 81;
        rx_idle_pct = 29;
        run_phase(0, 100);
        run_phase(0, 100);
        @(negedge aclk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(0, 100);
        @(negedge aclk);
        stall_armed = 1'b1;
        run_phase(2, 100);

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (drive_expected.size() != 0) begin
            $display("%0t: %0d expected drive values never arrived",
                     $time, drive_expected.size());
            errors++;
        end

        $display("Ran %0d samples over %0d register settings, incl. extremes and crossed limits.",
                 n_accepted, n_settings);
        $display("Checked %0d drive values, %0d clamped, %0d mismatching fields.",
                 n_checked, n_clamped, errors);
        if (errors == 0)
            $display("timestamped_pid_controller_core test passed");
        else
            $display("timestamped_pid_controller_core test failed");
        $finish;
    end

endmodule
